// ----- rtl/core/spp_pkg.sv -----
`default_nettype none

package spp_pkg;

	localparam int MAX_BINS   = 1024;
	localparam int HALF_BINS  = MAX_BINS / 2;
	localparam int MAX_PEAKS  = 16;

	localparam int MAG_W      = 16;
	localparam int BIN_W      = 9;
	localparam int NP_W       = 5;
	localparam int NP_RESET   = 4;
	localparam int OUT_DATA_W = 32;
	localparam int OUT_PAD_W  = OUT_DATA_W - MAG_W - BIN_W;

	localparam int CNT_W      = $clog2(MAX_BINS + 1);
	localparam int HALF_W     = $clog2(HALF_BINS + 1);
	localparam int ADDR_W     = $clog2(HALF_BINS);
	localparam int SLOT_W     = $clog2(MAX_PEAKS);
	localparam int FND_W      = $clog2(MAX_PEAKS + 1);
	localparam int PASS_W     = $clog2(2 * MAX_PEAKS + 1);

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_START,
		ST_SCAN_INIT,
		ST_SCAN,
		ST_MARK,
		ST_MARK_WR,
		ST_UP_RD,
		ST_UP_CHK,
		ST_DN_RD,
		ST_DN_CHK,
		ST_NEXT,
		ST_OUT,
		ST_CLEAR
	} state_t;

	typedef struct packed {
		logic load_en;
		logic search_init;
		logic scan_init;
		logic scan_run;
		logic mark_rd;
		logic mark_wr;
		logic up_rd;
		logic up_step;
		logic dn_init;
		logic dn_rd;
		logic dn_step;
		logic next_pass;
		logic out_load;
		logic clear;
	} cmd_t;

	typedef struct packed {
		logic frame_closed;
		logic want_zero;
		logic scan_done;
		logic half_zero;
		logic up_ok;
		logic dn_ok;
		logic fall;
		logic more_pass;
		logic out_free;
		logic out_last;
	} stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/spp_ctrl.sv -----
`default_nettype none

module spp_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire spp_pkg::stat_t st,
	output spp_pkg::cmd_t       cmd
);

	spp_pkg::state_t state_q;
	spp_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spp_pkg::ST_LOAD;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			spp_pkg::ST_LOAD: begin
				cmd.load_en = 1'b1;
				if (st.frame_closed) state_nxt = spp_pkg::ST_START;
			end
			spp_pkg::ST_START: begin
				cmd.search_init = 1'b1;
				state_nxt = st.want_zero ? spp_pkg::ST_CLEAR : spp_pkg::ST_SCAN_INIT;
			end
			spp_pkg::ST_SCAN_INIT: begin
				cmd.scan_init = 1'b1;
				state_nxt = spp_pkg::ST_SCAN;
			end
			spp_pkg::ST_SCAN: begin
				cmd.scan_run = 1'b1;
				if (st.scan_done) state_nxt = spp_pkg::ST_MARK;
			end
			spp_pkg::ST_MARK: begin
				cmd.mark_rd = 1'b1;
				state_nxt = st.half_zero ? spp_pkg::ST_NEXT : spp_pkg::ST_MARK_WR;
			end
			spp_pkg::ST_MARK_WR: begin
				cmd.mark_wr = 1'b1;
				state_nxt = spp_pkg::ST_UP_RD;
			end
			spp_pkg::ST_UP_RD: begin
				if (st.up_ok) begin
					cmd.up_rd = 1'b1;
					state_nxt = spp_pkg::ST_UP_CHK;
				end else begin
					cmd.dn_init = 1'b1;
					state_nxt = spp_pkg::ST_DN_RD;
				end
			end
			spp_pkg::ST_UP_CHK: begin
				if (st.fall) begin
					cmd.up_step = 1'b1;
					state_nxt = spp_pkg::ST_UP_RD;
				end else begin
					cmd.dn_init = 1'b1;
					state_nxt = spp_pkg::ST_DN_RD;
				end
			end
			spp_pkg::ST_DN_RD: begin
				if (st.dn_ok) begin
					cmd.dn_rd = 1'b1;
					state_nxt = spp_pkg::ST_DN_CHK;
				end else begin
					state_nxt = spp_pkg::ST_NEXT;
				end
			end
			spp_pkg::ST_DN_CHK: begin
				if (st.fall) begin
					cmd.dn_step = 1'b1;
					state_nxt = spp_pkg::ST_DN_RD;
				end else begin
					state_nxt = spp_pkg::ST_NEXT;
				end
			end
			spp_pkg::ST_NEXT: begin
				cmd.next_pass = 1'b1;
				state_nxt = st.more_pass ? spp_pkg::ST_SCAN_INIT : spp_pkg::ST_OUT;
			end
			spp_pkg::ST_OUT: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					if (st.out_last) state_nxt = spp_pkg::ST_CLEAR;
				end
			end
			spp_pkg::ST_CLEAR: begin
				cmd.clear = 1'b1;
				state_nxt = spp_pkg::ST_LOAD;
			end
			default: begin
				state_nxt = spp_pkg::ST_LOAD;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/core/spp_dp.sv -----
`default_nettype none

module spp_dp (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire spp_pkg::cmd_t                     cmd,
	output spp_pkg::stat_t                         st,
	input  wire logic                              cfg_we,
	input  wire logic [spp_pkg::NP_W-1:0]          cfg_wdata,
	input  wire logic                              s_tvalid,
	input  wire logic [spp_pkg::MAG_W-1:0]         s_tdata,
	input  wire logic                              s_tlast,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [spp_pkg::OUT_DATA_W-1:0]         m_tdata,
	output logic                                   m_tlast
);

	// bin store: {suppressed, magnitude}; flag cleared when the bin is loaded
	logic [spp_pkg::MAG_W:0]        bin_mem_q [spp_pkg::HALF_BINS];
	logic [spp_pkg::MAG_W:0]        rd_data_q;
	logic [spp_pkg::ADDR_W-1:0]     rd_addr;
	logic [spp_pkg::ADDR_W-1:0]     wr_addr;
	logic [spp_pkg::MAG_W:0]        wr_data;
	logic                           wr_en;
	logic [spp_pkg::MAG_W-1:0]      rd_mag;
	logic [spp_pkg::MAG_W-1:0]      scan_val;

	logic [spp_pkg::NP_W-1:0]       np_q;
	logic [spp_pkg::CNT_W-1:0]      cnt_q;
	logic [spp_pkg::NP_W-1:0]       want_q;
	logic [spp_pkg::NP_W-1:0]       want_w;
	logic [spp_pkg::HALF_W-1:0]     half_q;
	logic [spp_pkg::HALF_W-1:0]     j_q;
	logic                           rv_q;
	logic [spp_pkg::ADDR_W-1:0]     ja_q;
	logic [spp_pkg::MAG_W-1:0]      best_q;
	logic [spp_pkg::ADDR_W-1:0]     pos_q;
	logic [spp_pkg::ADDR_W-1:0]     p_q;
	logic [spp_pkg::MAG_W-1:0]      cur_q;
	logic [spp_pkg::MAG_W-1:0]      pm_q;
	logic [spp_pkg::FND_W-1:0]      found_q;
	logic [spp_pkg::PASS_W-1:0]     pass_q;
	logic [spp_pkg::SLOT_W-1:0]     k_q;

	logic [spp_pkg::BIN_W-1:0]      slot_bin_q [spp_pkg::MAX_PEAKS];
	logic [spp_pkg::MAG_W-1:0]      slot_amp_q [spp_pkg::MAX_PEAKS];

	logic                           out_valid_q;
	logic [spp_pkg::BIN_W-1:0]      out_bin_q;
	logic [spp_pkg::MAG_W-1:0]      out_amp_q;
	logic                           out_last_q;

	logic                           acc;
	logic                           k_hit;

	assign acc      = s_tvalid & cmd.load_en;
	assign rd_mag   = rd_data_q[spp_pkg::MAG_W-1:0];
	assign scan_val = rd_data_q[spp_pkg::MAG_W] ? '0 : rd_mag;
	assign want_w   = (np_q > spp_pkg::NP_W'(spp_pkg::MAX_PEAKS)) ?
	                  spp_pkg::NP_W'(spp_pkg::MAX_PEAKS) : np_q;
	assign k_hit    = spp_pkg::FND_W'(k_q) < found_q;

	// read / write port selection
	always_comb begin
		rd_addr = j_q[spp_pkg::ADDR_W-1:0];
		if (cmd.mark_rd) rd_addr = pos_q;
		if (cmd.up_rd)   rd_addr = p_q + spp_pkg::ADDR_W'(1);
		if (cmd.dn_rd)   rd_addr = p_q - spp_pkg::ADDR_W'(1);

		wr_en   = 1'b0;
		wr_addr = cnt_q[spp_pkg::ADDR_W-1:0];
		wr_data = {1'b0, s_tdata};
		if (acc && (cnt_q < spp_pkg::CNT_W'(spp_pkg::HALF_BINS))) wr_en = 1'b1;
		if (cmd.mark_wr) begin
			wr_en   = 1'b1;
			wr_addr = pos_q;
			wr_data = {1'b1, rd_mag};
		end
		if (cmd.up_step) begin
			wr_en   = 1'b1;
			wr_addr = p_q + spp_pkg::ADDR_W'(1);
			wr_data = {1'b1, rd_mag};
		end
		if (cmd.dn_step) begin
			wr_en   = 1'b1;
			wr_addr = p_q - spp_pkg::ADDR_W'(1);
			wr_data = {1'b1, rd_mag};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) bin_mem_q[wr_addr] <= wr_data;
		rd_data_q <= bin_mem_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.mark_rd && (pos_q != '0)) begin
			slot_bin_q[found_q[spp_pkg::SLOT_W-1:0]] <= spp_pkg::BIN_W'(pos_q);
			slot_amp_q[found_q[spp_pkg::SLOT_W-1:0]] <= best_q;
		end
		if (cmd.out_load) begin
			out_bin_q  <= k_hit ? slot_bin_q[k_q] : '0;
			out_amp_q  <= k_hit ? slot_amp_q[k_q] : '0;
			out_last_q <= st.out_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			np_q        <= spp_pkg::NP_W'(spp_pkg::NP_RESET);
			cnt_q       <= '0;
			want_q      <= '0;
			half_q      <= '0;
			j_q         <= '0;
			rv_q        <= 1'b0;
			ja_q        <= '0;
			best_q      <= '0;
			pos_q       <= '0;
			p_q         <= '0;
			cur_q       <= '0;
			pm_q        <= '0;
			found_q     <= '0;
			pass_q      <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) np_q <= cfg_wdata;

			if (acc && (cnt_q < spp_pkg::CNT_W'(spp_pkg::MAX_BINS))) begin
				cnt_q <= cnt_q + spp_pkg::CNT_W'(1);
			end
			if (cmd.clear) cnt_q <= '0;

			if (cmd.search_init) begin
				want_q  <= want_w;
				half_q  <= spp_pkg::HALF_W'(cnt_q >> 1);
				found_q <= '0;
				pass_q  <= '0;
				k_q     <= '0;
			end

			if (cmd.scan_init) begin
				j_q    <= '0;
				rv_q   <= 1'b0;
				best_q <= '0;
				pos_q  <= '0;
			end
			if (cmd.scan_run) begin
				if (j_q != half_q) begin
					j_q  <= j_q + spp_pkg::HALF_W'(1);
					ja_q <= j_q[spp_pkg::ADDR_W-1:0];
					rv_q <= 1'b1;
				end else begin
					rv_q <= 1'b0;
				end
				if (rv_q && (scan_val > best_q)) begin
					best_q <= scan_val;
					pos_q  <= ja_q;
				end
			end

			if (cmd.mark_rd && (pos_q != '0)) found_q <= found_q + spp_pkg::FND_W'(1);
			if (cmd.mark_wr) begin
				cur_q <= rd_mag;
				pm_q  <= rd_mag;
				p_q   <= pos_q;
			end
			if (cmd.up_step) begin
				cur_q <= rd_mag;
				p_q   <= p_q + spp_pkg::ADDR_W'(1);
			end
			if (cmd.dn_init) begin
				cur_q <= pm_q;
				p_q   <= pos_q;
			end
			if (cmd.dn_step) begin
				cur_q <= rd_mag;
				p_q   <= p_q - spp_pkg::ADDR_W'(1);
			end
			if (cmd.next_pass) pass_q <= pass_q + spp_pkg::PASS_W'(1);

			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
				k_q         <= k_q + spp_pkg::SLOT_W'(1);
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		st.frame_closed = acc & s_tlast;
		st.want_zero    = (want_w == '0);
		st.scan_done    = (j_q == half_q) && !rv_q;
		st.half_zero    = (half_q == '0);
		st.up_ok        = (spp_pkg::HALF_W'(p_q) + spp_pkg::HALF_W'(1)) < half_q;
		st.dn_ok        = (p_q != '0);
		st.fall         = rd_mag < cur_q;
		st.more_pass    = ((pass_q + spp_pkg::PASS_W'(1)) < (spp_pkg::PASS_W'(want_q) << 1))
		                  && (spp_pkg::FND_W'(found_q) < spp_pkg::FND_W'(want_q));
		st.out_free     = !out_valid_q || m_tready;
		st.out_last     = (spp_pkg::FND_W'(k_q) + spp_pkg::FND_W'(1)) ==
		                  spp_pkg::FND_W'(want_q);
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{spp_pkg::OUT_PAD_W{1'b0}}, out_amp_q, out_bin_q};
	assign m_tlast  = out_last_q;

endmodule

`default_nettype wire

// ----- rtl/core/spectral_peak_picker.sv -----
// Spectral peak picker.
// Slave stream: one spectrum bin per transfer, s_tdata = magnitude (16 bits,
// unsigned), s_tlast marks the final bin of the frame. Bins beyond 1024 are
// dropped; only the first 512 are stored, the search covers bins 0 to
// count/2-1.
// Master stream: exactly num_peaks transfers per frame, m_tdata = peak_bin
// in [8:0], peak_amplitude in [24:9]; m_tlast on the last one. Empty slots
// carry bin 0 and amplitude 0. num_peaks = 0 closes the frame silently.
// Config: cfg_we/cfg_wdata write num_peaks (reset 4, values above 16 act as
// 16); write only while idle.
// Timing: loading accepts one bin per cycle while s_tvalid is high. After the
// closing transfer come a start state and up to 2*num_peaks passes; each pass
// scans the stored half of the one-read, one-write bin memory, reads and marks
// the winner (not for an empty half), marks the falling lobe bin by bin on each
// side and ends in the next-pass state; peaks then go out at one per cycle while
// the receiver is ready. No bins are accepted during search or output; s_tready
// returns after the clear state that follows the loading of the last result into
// the output register, so a stalled receiver holds it while loading resumes.
// Reset clears the frame and the output register; no clearing pass.
`default_nettype none

module spectral_peak_picker (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// slave stream
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [spp_pkg::MAG_W-1:0]         s_tdata,    // [15:0] magnitude
	input  wire logic                              s_tlast,
	// master stream
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [spp_pkg::OUT_DATA_W-1:0]         m_tdata,    // [8:0] peak_bin, [24:9] peak_amplitude
	output logic                                   m_tlast,
	// num_peaks register write
	input  wire logic                              cfg_we,
	input  wire logic [spp_pkg::NP_W-1:0]          cfg_wdata
);

	spp_pkg::cmd_t  cmd;
	spp_pkg::stat_t st;

	spp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.cmd    (cmd)
	);

	spp_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	// intake only in the load phase
	assign s_tready = cmd.load_en;

	// a closing transfer stops intake at once
	a_close_stops_intake: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("intake still open after frame close");

	// loading bins and emitting results never overlap
	a_no_load_during_out: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && cmd.out_load))
		else $error("result loaded while bins are accepted");

	// a loaded result is presented on the next cycle
	a_out_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> m_tvalid)
		else $error("loaded result not presented");

endmodule

`default_nettype wire

// ----- dv/spectral_peak_picker_test.sv -----
module spectral_peak_picker_test;
	import spp_pkg::*;

	typedef logic [MAG_W-1:0] mag_list_t [$];

	// one peak report as it leaves the master stream
	typedef struct packed {
		logic [BIN_W-1:0] pos;
		logic [MAG_W-1:0] amp;
		logic             last;
	} peak_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [MAG_W-1:0]      s_tdata   = '0;     // [15:0] magnitude
	logic                  s_tlast   = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;            // [8:0] peak_bin, [24:9] peak_amplitude
	logic                  m_tlast;
	logic                  cfg_we    = 1'b0;
	logic [NP_W-1:0]       cfg_wdata = '0;

	spectral_peak_picker DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #6 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor state: stored lower half of the open frame, lobe marks,
	// bin count and the num_peaks value the block is expected to hold.
	// ------------------------------------------------------------------
	logic [MAG_W-1:0] spectrum [HALF_BINS];
	bit               lobe_mask [HALF_BINS];
	int unsigned      bins_open   = 0;
	logic [NP_W-1:0]  peak_target = NP_RESET;
	peak_t            peak_queue [$];

	// traffic shaping knobs
	bit tx_idling   = 1'b1;
	bit rx_idling   = 1'b1;
	int rx_hold     = 0;     // long receiver hold-off, counted down per cycle
	int rx_stall    = 0;     // short random receiver stall
	int error_count = 0;

	peak_t seen_peak;
	peak_t due_peak;

	// Runs the peak search over the closed frame and queues its reports.
	// Winner is the first strictly largest unmarked bin; a DC winner is
	// marked but not reported. Lobes are marked while magnitudes fall.
	function automatic void close_frame();
		int    want, half, found, pass, best, where, p, j, k;
		peak_t slots [MAX_PEAKS];
		want  = (peak_target > MAX_PEAKS) ? MAX_PEAKS : peak_target;
		half  = (bins_open / 2 > HALF_BINS) ? HALF_BINS : bins_open / 2;
		found = 0;
		for (k = 0; k < MAX_PEAKS; k++)
			slots[k] = '0;
		for (pass = 0; pass < 2 * want && found < want; pass++) begin
			best  = 0;
			where = 0;
			for (j = 0; j < half; j++)
				if (!lobe_mask[j] && int'(spectrum[j]) > best) begin
					best  = spectrum[j];
					where = j;
				end
			if (where != 0) begin
				slots[found].pos = where;
				slots[found].amp = best;
				found++;
			end
			lobe_mask[where] = 1'b1;
			for (p = where; p + 1 < half && spectrum[p + 1] < spectrum[p]; p++)
				lobe_mask[p + 1] = 1'b1;
			for (p = where; p > 0 && spectrum[p - 1] < spectrum[p]; p--)
				lobe_mask[p - 1] = 1'b1;
		end
		for (k = 0; k < want; k++) begin
			slots[k].last = (k == want - 1);
			peak_queue.push_back(slots[k]);
		end
		for (j = 0; j < HALF_BINS; j++)
			lobe_mask[j] = 1'b0;
		bins_open = 0;
	endfunction

	// Bin count saturates at MAX_BINS; only the lower half is stored.
	function automatic void absorb_bin(logic [MAG_W-1:0] mag, logic closing);
		if (bins_open < MAX_BINS) begin
			if (bins_open < HALF_BINS)
				spectrum[bins_open] = mag;
			bins_open++;
		end
		if (closing)
			close_frame();
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(30, 90);
	endfunction

	function automatic logic [NP_W-1:0] pick_peak_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 1;
		if (r < 20)
			return MAX_PEAKS;
		if (r < 25)
			return 0;
		if (r < 30)
			return $urandom_range(MAX_PEAKS + 1, (1 << NP_W) - 1);
		return $urandom_range(1, MAX_PEAKS);
	endfunction

	function automatic int pick_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 12)
			return $urandom_range(1, 3);
		if (r < 87)
			return $urandom_range(4, 32);
		if (r < 97)
			return $urandom_range(33, 120);
		return $urandom_range(121, 300);
	endfunction

	// Frame content: full-range noise, tiny values (ties, plateaus), or a
	// low floor with peaks whose lobes fall off in straight steps.
	function automatic mag_list_t random_frame(int n);
		mag_list_t mags;
		int        style, peaks, pos, height, step, d, v, j;
		style = $urandom_range(0, 9);
		for (j = 0; j < n; j++) begin
			if (style < 2)
				mags.push_back($urandom_range(0, 65535));
			else if (style < 4)
				mags.push_back($urandom_range(0, 7));
			else
				mags.push_back($urandom_range(0, 255));
			if ($urandom_range(0, 47) == 0)
				mags[j] = 16'hFFFF;
		end
		if (style >= 4) begin
			peaks = $urandom_range(1, n / 4 + 1);
			repeat (peaks) begin
				pos    = $urandom_range(0, n - 1);
				height = $urandom_range(256, 65535);
				step   = $urandom_range(1, height / 4 + 1);
				for (d = -8; d <= 8; d++) begin
					v = height - ((d < 0) ? -d : d) * step;
					if (pos + d >= 0 && pos + d < n && v > 0 && v > int'(mags[pos + d]))
						mags[pos + d] = v;
				end
			end
		end
		return mags;
	endfunction

	task automatic flag_mismatch(string what, int unsigned got, int unsigned want);
		$display("MISMATCH %s: got %0d, expected %0d", what, got, want);
		error_count++;
	endtask

	// One slave-side transfer; the predictor sees it when it is taken.
	task automatic push_bin(logic [MAG_W-1:0] mag, logic closing);
		int gap;
		gap = tx_idling ? pick_gap() : 0;
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= mag;
		s_tlast  <= closing;
		do @(posedge clk); while (!s_tready);
		absorb_bin(mag, closing);
	endtask

	task automatic send_frame(mag_list_t mags);
		int i;
		for (i = 0; i < mags.size(); i++)
			push_bin(mags[i], i == mags.size() - 1);
	endtask

	task automatic sender_rest();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	task automatic wait_results();
		sender_rest();
		while (peak_queue.size() != 0)
			@(posedge clk);
	endtask

	// A frame with num_peaks 0 gives no report to wait for, so allow the
	// block a full half-memory sweep before touching the register.
	task automatic write_peak_count(logic [NP_W-1:0] value);
		wait_results();
		repeat (HALF_BINS + 64) @(posedge clk);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		peak_target = value;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_directed();
		mag_list_t mags;
		// reset value of num_peaks; DC largest, a tie, all-ones/alternating
		// bit patterns; upper half zero and never searched
		mags = '{16'hFFFF, 16'd7, 16'd900, 16'd900, 16'h5555, 16'hAAAA,
			16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
		send_frame(mags);
		// single-bin frame: empty search half, every slot empty
		mags = '{16'd12345};
		send_frame(mags);
		// zero peaks: frame closes without a report
		write_peak_count(0);
		mags = '{16'd100, 16'd200, 16'd300};
		send_frame(mags);
		// above the slot count: acts as the maximum, mostly empty slots
		write_peak_count((1 << NP_W) - 1);
		mags = '{16'd10, 16'd0, 16'd50, 16'd0, 16'd0, 16'd0};
		send_frame(mags);
		// minimum count, peak at the all-ones magnitude
		write_peak_count(1);
		mags = '{16'd0, 16'hFFFF, 16'd3, 16'd2};
		send_frame(mags);
	endtask

	// More bins than the block holds: count saturates, bins past the
	// stored half never matter, top searched bin 511 can still win.
	task automatic test_over_capacity();
		mag_list_t mags;
		int        j;
		write_peak_count(2);
		for (j = 0; j < MAX_BINS + 6; j++)
			mags.push_back((j < HALF_BINS) ? $urandom_range(0, 1000) : 16'hFFFF);
		mags[5]             = 16'd40000;
		mags[HALF_BINS - 2] = 16'd59000;
		mags[HALF_BINS - 1] = 16'd60000;
		tx_idling = 1'b0;
		send_frame(mags);
		tx_idling = 1'b1;
		wait_results();
	endtask

	// Receiver stops for a long stretch while the next frame is offered,
	// so the output register fills and the slave side stalls.
	task automatic test_backpressure();
		write_peak_count(MAX_PEAKS);
		send_frame(random_frame(20));
		// start the hold once the first report is up, so the search time
		// does not use it up
		wait (m_tvalid === 1'b1);
		rx_hold = 700;
		send_frame(random_frame(20));
		wait_results();
	endtask

	// Sender waits for every report, then sends back to back.
	task automatic test_drain_pause();
		write_peak_count($urandom_range(1, MAX_PEAKS));
		send_frame(random_frame(24));
		wait_results();
		tx_idling = 1'b0;
		rx_idling = 1'b0;
		send_frame(random_frame(24));
		send_frame(random_frame(10));
		tx_idling = 1'b1;
		rx_idling = 1'b1;
		wait_results();
	endtask

	task automatic test_random();
		int sent, n;
		sent = 0;
		while (sent < 460) begin
			if ($urandom_range(0, 99) < 35)
				write_peak_count(pick_peak_count());
			tx_idling = ($urandom_range(0, 3) != 0);
			rx_idling = ($urandom_range(0, 3) != 0);
			n = pick_length();
			send_frame(random_frame(n));
			sent += n;
		end
	endtask

	// ------------------------------------------------------------------
	// Receiver: drives m_tready at the falling edge
	// ------------------------------------------------------------------
	initial begin
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				m_tready <= 1'b0;
				rx_hold--;
			end else if (rx_stall > 0) begin
				m_tready <= 1'b0;
				rx_stall--;
			end else begin
				m_tready <= 1'b1;
				if (rx_idling && $urandom_range(0, 3) == 0)
					rx_stall = pick_gap();
			end
		end
	end

	// Result check against the oldest queued report
	always @(posedge clk) begin
		if (m_tvalid === 1'b1 && m_tready) begin
			seen_peak = {m_tdata[BIN_W-1:0], m_tdata[BIN_W +: MAG_W], m_tlast};
			if (peak_queue.size() == 0) begin
				flag_mismatch("report with none pending, peak_bin", seen_peak.pos, 0);
			end else begin
				due_peak = peak_queue.pop_front();
				if (seen_peak.pos != due_peak.pos)
					flag_mismatch("peak_bin", seen_peak.pos, due_peak.pos);
				if (seen_peak.amp != due_peak.amp)
					flag_mismatch("peak_amplitude", seen_peak.amp, due_peak.amp);
				if (seen_peak.last != due_peak.last)
					flag_mismatch("last_peak", seen_peak.last, due_peak.last);
			end
		end
	end

	initial begin
		#200000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int spin;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_over_capacity();
		test_backpressure();
		test_drain_pause();
		test_random();

		sender_rest();
		for (spin = 0; spin < 200000 && peak_queue.size() != 0; spin++)
			@(posedge clk);
		repeat (HALF_BINS + 64) @(posedge clk);
		if (peak_queue.size() != 0)
			flag_mismatch("reports never delivered", 0, peak_queue.size());

		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/spp_pkg.sv
rtl/core/spp_ctrl.sv
rtl/core/spp_dp.sv
rtl/core/spectral_peak_picker.sv
dv/spectral_peak_picker_test.sv
